/* hw/rtl/bda_pkg.sv */
`timescale 1ns / 1ps

package bda_pkg;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned TIME_W  = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_REPEAT     = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd40;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd800;
  localparam logic [CFG_W-1:0] REPEAT_RESET     = 16'd120;

  localparam logic [7:0] BTN_MASK   = 8'hF8;
  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam int unsigned BIT_UP    = 7;
  localparam int unsigned BIT_SEL   = 6;
  localparam int unsigned BIT_DOWN  = 5;
  localparam int unsigned BIT_RIGHT = 4;
  localparam int unsigned BIT_LEFT  = 3;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
    logic [CFG_W-1:0] repeat_interval;
  } cfg_t;

  typedef struct packed {
    logic any_key;
    logic left_event;
    logic right_event;
    logic select_event;
    logic up_event;
    logic down_event;
  } result_t;

endpackage

/* hw/rtl/bda_cfg_regs.sv */
`timescale 1ns / 1ps

module bda_cfg_regs import bda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time   <= DEBOUNCE_RESET;
      cfg.long_press_time <= LONG_PRESS_RESET;
      cfg.repeat_interval <= REPEAT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DEBOUNCE:   cfg.debounce_time   <= pwdata[CFG_W-1:0];
        REG_LONG_PRESS: cfg.long_press_time <= pwdata[CFG_W-1:0];
        REG_REPEAT:     cfg.repeat_interval <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE:   prdata = {{(PDATA_W-CFG_W){1'b0}}, cfg.debounce_time};
      REG_LONG_PRESS: prdata = {{(PDATA_W-CFG_W){1'b0}}, cfg.long_press_time};
      REG_REPEAT:     prdata = {{(PDATA_W-CFG_W){1'b0}}, cfg.repeat_interval};
      default:        prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/bda_poll.sv */
`timescale 1ns / 1ps

module bda_poll import bda_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              step,
  input  logic [TIME_W-1:0] time_ms,
  input  logic [7:0]        button_byte,
  input  logic              screen_asleep,
  output result_t           res
);

  logic [7:0]        previous_byte, previous_byte_next;
  logic [TIME_W-1:0] last_event_time, last_event_time_next;
  logic [TIME_W-1:0] last_repeat_time, last_repeat_time_next;
  logic              repeat_active, repeat_active_next;

  logic [7:0]        down_bits, prev_down, fresh;
  logic              any, wake, repeat_due, suppress, acted, held;
  logic [TIME_W-1:0] since_event, since_repeat, since_event_new;
  logic              ev_l, ev_r, ev_s, ev_u, ev_d;

  always_comb begin
    down_bits    = ~button_byte & BTN_MASK;
    prev_down    = ~previous_byte & BTN_MASK;
    fresh        = down_bits & ~prev_down;
    any          = |down_bits;
    wake         = any && screen_asleep;
    since_event  = time_ms - last_event_time;
    since_repeat = time_ms - last_repeat_time;
    repeat_due   = repeat_active &&
                   (since_repeat >= {{(TIME_W-CFG_W){1'b0}}, cfg.repeat_interval});
    suppress     = (since_event < {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time}) &&
                   !repeat_due;

    ev_l  = fresh[BIT_LEFT];
    ev_r  = fresh[BIT_RIGHT];
    ev_s  = fresh[BIT_SEL];
    ev_u  = fresh[BIT_UP] || (down_bits[BIT_UP] && repeat_due);
    ev_d  = fresh[BIT_DOWN] || (down_bits[BIT_DOWN] && repeat_due);
    acted = ev_l || ev_r || ev_s || ev_u || ev_d;
    held  = down_bits[BIT_UP] || down_bits[BIT_DOWN];

    // an event restarts the elapsed time from zero
    since_event_new = acted ? '0 : since_event;

    previous_byte_next    = previous_byte;
    last_event_time_next  = last_event_time;
    last_repeat_time_next = last_repeat_time;
    repeat_active_next    = repeat_active;

    if (!wake) begin
      previous_byte_next = button_byte;
      if (!suppress) begin
        if (acted) begin
          last_event_time_next = time_ms;
        end
        if (held && (last_event_time_next != '0) &&
            (since_event_new >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_time})) begin
          repeat_active_next    = 1'b1;
          last_repeat_time_next = time_ms;
        end else if (!held) begin
          repeat_active_next = 1'b0;
        end
      end
    end

    res.any_key      = any && !screen_asleep;
    res.left_event   = !wake && !suppress && ev_l;
    res.right_event  = !wake && !suppress && ev_r;
    res.select_event = !wake && !suppress && ev_s;
    res.up_event     = !wake && !suppress && ev_u;
    res.down_event   = !wake && !suppress && ev_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte    <= BYTE_IDLE;
      last_event_time  <= '0;
      last_repeat_time <= '0;
      repeat_active    <= 1'b0;
    end else if (step) begin
      previous_byte    <= previous_byte_next;
      last_event_time  <= last_event_time_next;
      last_repeat_time <= last_repeat_time_next;
      repeat_active    <= repeat_active_next;
    end
  end

endmodule

/* hw/rtl/button_edge_debounce_autorepeat.sv */
`timescale 1ns / 1ps

// Button poller with debounce and up/down auto-repeat. Every poll gives exactly one
// result, and a new poll can be taken every clock cycle while no result is held by
// out_stall. The poll goes into an input register at the transfer edge, and the
// result register is loaded from it once the output side is free to take it. All of
// the debounce, edge and repeat logic sits between the two registers. A result held
// by out_stall keeps the input register full, and in_stall then holds off further
// polls. The debounce, long-press and repeat times sit in three 16-bit registers at
// byte addresses 0, 4 and 8, and should only be written while no poll is in flight.

module button_edge_debounce_autorepeat import bda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [TIME_W-1:0]  time_ms,
  input  logic [7:0]         button_byte,
  input  logic               screen_asleep,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               any_key,
  output logic               left_event,
  output logic               right_event,
  output logic               select_event,
  output logic               up_event,
  output logic               down_event
);

  cfg_t              cfg;
  result_t           res, res_q;
  logic              s1_valid;
  logic [TIME_W-1:0] s1_time;
  logic [7:0]        s1_byte;
  logic              s1_asleep;
  logic              out_free, step, in_take;

  bda_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bda_poll u_poll (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .step          (step),
    .time_ms       (s1_time),
    .button_byte   (s1_byte),
    .screen_asleep (s1_asleep),
    .res           (res)
  );

  assign out_free = !out_valid || !out_stall;
  assign step     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (step) begin
        s1_valid <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_time   <= time_ms;
      s1_byte   <= button_byte;
      s1_asleep <= screen_asleep;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign any_key      = res_q.any_key;
  assign left_event   = res_q.left_event;
  assign right_event  = res_q.right_event;
  assign select_event = res_q.select_event;
  assign up_event     = res_q.up_event;
  assign down_event   = res_q.down_event;

endmodule

/* hw/rtl/bda_checker.sv */
`timescale 1ns / 1ps

module bda_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic any_key,
  input logic left_event,
  input logic right_event,
  input logic select_event,
  input logic up_event,
  input logic down_event
);

  // no event can fire unless some button is reported down
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (left_event || right_event || select_event || up_event || down_event)
    |-> any_key)
    else $error("event without any_key");

  // input side only backs up when the result register is full and held
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({any_key, left_event, right_event,
                                                     select_event, up_event, down_event}))
    else $error("held result changed");

endmodule

bind button_edge_debounce_autorepeat bda_checker u_bda_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .any_key      (any_key),
  .left_event   (left_event),
  .right_event  (right_event),
  .select_event (select_event),
  .up_event     (up_event),
  .down_event   (down_event)
);

/* dv/button_edge_debounce_autorepeat_test.sv */
`timescale 1ns / 1ps

module button_edge_debounce_autorepeat_test;
  import bda_pkg::*;

  // index 3 decodes to no register
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  pad;
    logic        sleep;
    logic        typed;
    result_t     want;
  } poll_row_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [TIME_W-1:0]  time_ms;
  logic [7:0]         button_byte;
  logic               screen_asleep;
  logic               out_valid;
  logic               out_stall;
  logic               any_key;
  logic               left_event;
  logic               right_event;
  logic               select_event;
  logic               up_event;
  logic               down_event;

  // predictor copy of the registers and poller state
  cfg_t        cfg;
  logic [7:0]  prev_byte;
  logic [31:0] last_event_ms;
  logic [31:0] last_repeat_ms;
  logic        repeat_on;

  result_t     pending_results [$];
  int unsigned mismatches;
  bit          gaps_on;
  int unsigned stall_left;
  int unsigned stall_draw;

  poll_row_t directed_polls [0:21] = '{
    '{32'd0,          8'hFF, 1'b0, 1'b1, 6'b000000},  // nothing pressed after reset
    '{32'd100,        8'h7F, 1'b1, 1'b1, 6'b000000},  // wake press is swallowed
    '{32'd100,        8'h00, 1'b1, 1'b1, 6'b000000},  // every bit low while asleep
    '{32'd100,        8'hFF, 1'b1, 1'b1, 6'b000000},  // asleep ignored with no button
    '{32'd200,        8'hF7, 1'b0, 1'b1, 6'b110000},
    '{32'd210,        8'hFF, 1'b0, 1'b1, 6'b000000},
    '{32'd220,        8'hEF, 1'b0, 1'b1, 6'b100000},  // right inside debounce window
    '{32'd300,        8'hBF, 1'b0, 1'b1, 6'b100100},
    '{32'd400,        8'h07, 1'b0, 1'b1, 6'b111011},  // select already held
    '{32'd1200,       8'h7F, 1'b0, 1'b0, 6'b000000},  // long press arms repeat
    '{32'd1320,       8'h7F, 1'b0, 1'b0, 6'b000000},
    '{32'd1330,       8'h7F, 1'b0, 1'b0, 6'b000000},  // repeat overrides debounce
    '{32'd1340,       8'hDF, 1'b0, 1'b0, 6'b000000},
    '{32'd1500,       8'h5F, 1'b0, 1'b0, 6'b000000},
    '{32'hFFFF_FFF0,  8'hFF, 1'b0, 1'b0, 6'b000000},
    '{32'h0000_0010,  8'hF8, 1'b0, 1'b1, 6'b000000},  // only the unused bits low
    '{32'h0000_0020,  8'h77, 1'b0, 1'b0, 6'b000000},  // differences across the wrap
    '{32'hFFFF_FFFF,  8'hFF, 1'b0, 1'b1, 6'b000000},
    '{32'h0000_1000,  8'hFF, 1'b0, 1'b1, 6'b000000},
    '{32'h0000_0000,  8'h7F, 1'b0, 1'b0, 6'b000000},  // event stamped at time zero
    '{32'h0000_2000,  8'h7F, 1'b0, 1'b0, 6'b000000},  // so no repeat may start
    '{32'h0000_2100,  8'h7F, 1'b0, 1'b0, 6'b000000}
  };

  button_edge_debounce_autorepeat u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .time_ms      (time_ms),
    .button_byte  (button_byte),
    .screen_asleep(screen_asleep),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .any_key      (any_key),
    .left_event   (left_event),
    .right_event  (right_event),
    .select_event (select_event),
    .up_event     (up_event),
    .down_event   (down_event)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t poll_outcome(input logic [31:0] stamp, input logic [7:0] pad,
                                           input logic sleep);
    result_t     r;
    logic [7:0]  pressed;
    logic [7:0]  fresh;
    logic [31:0] since_event;
    logic        due;
    logic        held;
    r = '0;
    pressed = ~pad & BTN_MASK;
    if (pressed != 8'h00 && sleep) return r;
    r.any_key = (pressed != 8'h00);
    fresh = pressed & ~(~prev_byte & BTN_MASK);
    prev_byte = pad;
    due = repeat_on && ((stamp - last_repeat_ms) >= {16'h0, cfg.repeat_interval});
    since_event = stamp - last_event_ms;
    if (since_event < {16'h0, cfg.debounce_time} && !due) return r;
    r.left_event   = fresh[BIT_LEFT];
    r.right_event  = fresh[BIT_RIGHT];
    r.select_event = fresh[BIT_SEL];
    r.up_event     = fresh[BIT_UP] | (pressed[BIT_UP] & due);
    r.down_event   = fresh[BIT_DOWN] | (pressed[BIT_DOWN] & due);
    if (r.left_event | r.right_event | r.select_event | r.up_event | r.down_event)
      last_event_ms = stamp;
    held = pressed[BIT_UP] | pressed[BIT_DOWN];
    if (held && last_event_ms != 32'h0 &&
        (stamp - last_event_ms) >= {16'h0, cfg.long_press_time}) begin
      repeat_on = 1'b1;
      last_repeat_ms = stamp;
    end else if (!held) begin
      repeat_on = 1'b0;
    end
    return r;
  endfunction

  function automatic void check_bit(input string name, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // psel and penable are left high at the end; the caller drops them once the run of
  // register accesses is over
  task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DEBOUNCE:   cfg.debounce_time = val;
      REG_LONG_PRESS: cfg.long_press_time = val;
      REG_REPEAT:     cfg.repeat_interval = val;
      default: ;
    endcase
  endtask

  task automatic reg_read_check(input logic [1:0] idx, input logic [15:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0, want}) begin
      $display("%0t: register %0d expected %0h actual %0h", $time, idx, want, prdata);
      mismatches++;
    end
  endtask

  task automatic send_poll(input logic [31:0] stamp, input logic [7:0] pad, input logic sleep,
                           input logic typed, input result_t want);
    int unsigned gap;
    result_t     predicted;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    time_ms       <= stamp;
    button_byte   <= pad;
    screen_asleep <= sleep;
    do @(posedge clk); while (in_stall);
    predicted = poll_outcome(stamp, pad, sleep);
    pending_results.push_back(typed ? want : predicted);
    if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_polls(input int unsigned count);
    int unsigned step_max;
    int unsigned k;
    logic [31:0] stamp;
    logic [7:0]  pad;
    logic        sleep;
    step_max = (cfg.debounce_time + cfg.long_press_time / 2 + cfg.repeat_interval) / 2 + 8;
    stamp = $urandom();
    pad = BYTE_IDLE;
    for (k = 0; k < count; k++) begin
      // mostly a steadily advancing clock, now and then a jump anywhere
      if ($urandom_range(0, 39) == 0) stamp = $urandom();
      else stamp = stamp + $urandom_range(0, step_max);
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 4))
          0: pad = BYTE_IDLE;
          1: pad = ~(8'h08 << $urandom_range(0, 4));
          2: pad = 8'($urandom());
          3: pad = $urandom_range(0, 1) ? ~(8'h01 << BIT_UP) : ~(8'h01 << BIT_DOWN);
          default: pad = pad & ~(8'h08 << $urandom_range(0, 4));
        endcase
      end
      pad[2:0] = 3'($urandom());
      sleep = ($urandom_range(0, 11) == 0);
      send_poll(stamp, pad, sleep, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input logic [15:0] deb, input logic [15:0] hold,
                           input logic [15:0] rep, input int unsigned count);
    drain;
    reg_write(REG_DEBOUNCE, deb);
    reg_write(REG_LONG_PRESS, hold);
    reg_write(REG_REPEAT, rep);
    reg_write(REG_NONE, 16'($urandom()));
    reg_read_check(REG_DEBOUNCE, cfg.debounce_time);
    reg_read_check(REG_LONG_PRESS, cfg.long_press_time);
    reg_read_check(REG_REPEAT, cfg.repeat_interval);
    psel    <= 1'b0;
    penable <= 1'b0;
    random_polls(count);
  endtask

  // result side: after each transfer hold off for a random number of cycles
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else if (out_valid) begin
      stall_draw = gaps_on ? $urandom_range(0, 5) : 0;
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $time);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_bit("any_key", want.any_key, any_key);
        check_bit("left_event", want.left_event, left_event);
        check_bit("right_event", want.right_event, right_event);
        check_bit("select_event", want.select_event, select_event);
        check_bit("up_event", want.up_event, up_event);
        check_bit("down_event", want.down_event, down_event);
      end
    end
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    time_ms       = '0;
    button_byte   = BYTE_IDLE;
    screen_asleep = 1'b0;
    out_stall     = 1'b0;
    mismatches    = 0;
    gaps_on       = 1'b1;
    cfg           = '{DEBOUNCE_RESET, LONG_PRESS_RESET, REPEAT_RESET};
    prev_byte      = BYTE_IDLE;
    last_event_ms  = '0;
    last_repeat_ms = '0;
    repeat_on      = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    reg_read_check(REG_DEBOUNCE, DEBOUNCE_RESET);
    reg_read_check(REG_LONG_PRESS, LONG_PRESS_RESET);
    reg_read_check(REG_REPEAT, REPEAT_RESET);
    psel    <= 1'b0;
    penable <= 1'b0;
    foreach (directed_polls[i])
      send_poll(directed_polls[i].stamp, directed_polls[i].pad, directed_polls[i].sleep,
                directed_polls[i].typed, directed_polls[i].want);

    run_phase(16'd0, 16'd0, 16'd0, 235);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 235);
    run_phase(16'd5, 16'd100, 16'd10, 235);
    run_phase(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
              16'($urandom_range(0, 2000)), 235);
    run_phase(16'($urandom()), 16'($urandom()), 16'($urandom()), 235);
    run_phase(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
              16'($urandom_range(0, 200)), 235);
    run_phase(16'hFFFF, 16'd0, 16'd1, 235);
    run_phase(16'd0, 16'hFFFF, 16'hFFFF, 235);

    drain;
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* button_edge_debounce_autorepeat.f */
hw/rtl/bda_pkg.sv
hw/rtl/bda_cfg_regs.sv
hw/rtl/bda_poll.sv
hw/rtl/button_edge_debounce_autorepeat.sv
hw/rtl/bda_checker.sv
dv/button_edge_debounce_autorepeat_test.sv
